/* hw/rtl/shrc_pkg.sv */
// Shared types and constants of the startup hold request coalescer.
`default_nettype none

package shrc_pkg;

  typedef enum logic [1:0] {
    CMD_STARTUP_BEGIN  = 2'd0,
    CMD_STARTUP_FINISH = 2'd1,
    CMD_REQUEST        = 2'd2,
    CMD_POLL           = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    VERDICT_IDLE      = 3'd0,
    VERDICT_DEBOUNCED = 3'd1,
    VERDICT_QUEUED    = 3'd2,
    VERDICT_COALESCED = 3'd3,
    VERDICT_REBUILD   = 3'd4
  } verdict_e;

  localparam int unsigned TimeW   = 48;
  localparam int unsigned CountW  = 16;
  localparam int unsigned ReasonW = 8;
  localparam int unsigned CfgW    = 32;

  localparam logic CFG_DEBOUNCE = 1'b0;
  localparam logic CFG_TIMEOUT  = 1'b1;

  localparam logic [CfgW-1:0]   DEBOUNCE_RESET = 32'd1000;
  localparam logic [CfgW-1:0]   TIMEOUT_RESET  = 32'd30000;
  localparam logic [CountW-1:0] COUNT_MAX      = 16'hFFFF;

  typedef struct packed {
    verdict_e             verdict;
    logic [CountW-1:0]    count;
    logic [ReasonW-1:0]   reason;
    logic [TimeW-1:0]     waited;
    logic                 timed_out;
  } result_t;

  // Elapsed time, clamped at zero when time runs backwards.
  function automatic logic [TimeW-1:0] elapsed(input logic [TimeW-1:0] now,
                                               input logic [TimeW-1:0] then);
    elapsed = (now > then) ? (now - then) : '0;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/shrc_core.sv */
// Gate state and combinational decision logic for one command.
`default_nettype none

module shrc_core import shrc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic [1:0]         command_i,
  input  wire logic [TimeW-1:0]   now_ms_i,
  input  wire logic [ReasonW-1:0] reason_code_i,
  input  wire logic [CfgW-1:0]    debounce_i,
  input  wire logic [CfgW-1:0]    timeout_i,
  output result_t                 result_o
);

  logic               active_q, active_d;
  logic [TimeW-1:0]   begin_q, begin_d;
  logic               pending_q, pending_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [TimeW-1:0]   since_q, since_d;
  logic [ReasonW-1:0] reason_q, reason_d;
  logic [TimeW-1:0]   last_q, last_d;
  logic               released_q, released_d;

  logic [TimeW-1:0]  since_release;
  logic              debounce_hit;
  logic              holds;
  logic [TimeW-1:0]  waited_pend;
  logic [CountW-1:0] count_inc;

  assign since_release = now_ms_i - last_q;
  assign debounce_hit  = released_q && (now_ms_i >= last_q) &&
                         (since_release < {{(TimeW-CfgW){1'b0}}, debounce_i});
  assign holds         = active_q &&
                         (elapsed(now_ms_i, begin_q) < {{(TimeW-CfgW){1'b0}}, timeout_i});
  assign waited_pend   = pending_q ? elapsed(now_ms_i, since_q) : '0;
  assign count_inc     = (count_q == COUNT_MAX) ? count_q : count_q + 16'd1;

  always_comb begin
    result_o   = '0;
    active_d   = active_q;
    begin_d    = begin_q;
    pending_d  = pending_q;
    count_d    = count_q;
    since_d    = since_q;
    reason_d   = reason_q;
    last_d     = last_q;
    released_d = released_q;
    case (cmd_e'(command_i))
      CMD_STARTUP_BEGIN: begin
        active_d = 1'b1;
        begin_d  = now_ms_i;
      end
      CMD_STARTUP_FINISH: begin
        active_d = 1'b0;
      end
      CMD_REQUEST: begin
        if (debounce_hit) begin
          result_o.verdict = VERDICT_DEBOUNCED;
          result_o.reason  = reason_code_i;
        end else if (holds) begin
          result_o.verdict = pending_q ? VERDICT_COALESCED : VERDICT_QUEUED;
          result_o.count   = count_inc;
          result_o.reason  = reason_code_i;
          result_o.waited  = waited_pend;
          pending_d        = 1'b1;
          if (!pending_q) begin
            since_d = now_ms_i;
          end
          count_d  = count_inc;
          reason_d = reason_code_i;
        end else begin
          result_o.verdict   = VERDICT_REBUILD;
          result_o.count     = count_inc;
          result_o.reason    = reason_code_i;
          result_o.waited    = waited_pend;
          result_o.timed_out = active_q;
          pending_d  = 1'b0;
          count_d    = '0;
          since_d    = '0;
          reason_d   = '0;
          last_d     = now_ms_i;
          released_d = 1'b1;
        end
      end
      CMD_POLL: begin
        if (pending_q && !holds) begin
          result_o.verdict   = VERDICT_REBUILD;
          result_o.count     = (count_q == '0) ? 16'd1 : count_q;
          result_o.reason    = reason_q;
          result_o.waited    = waited_pend;
          result_o.timed_out = active_q;
          pending_d  = 1'b0;
          count_d    = '0;
          since_d    = '0;
          reason_d   = '0;
          last_d     = now_ms_i;
          released_d = 1'b1;
        end
      end
      default: begin
        result_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      begin_q    <= '0;
      pending_q  <= 1'b0;
      count_q    <= '0;
      since_q    <= '0;
      reason_q   <= '0;
      last_q     <= '0;
      released_q <= 1'b0;
    end else if (en_i) begin
      active_q   <= active_d;
      begin_q    <= begin_d;
      pending_q  <= pending_d;
      count_q    <= count_d;
      since_q    <= since_d;
      reason_q   <= reason_d;
      last_q     <= last_d;
      released_q <= released_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/startup_hold_request_coalescer.sv */
// Top level of the startup hold request coalescer: channel registers and configuration.
`default_nettype none

// Channel   Direction  Handshake             Payload
// input     in         in_valid_i/in_stall_o  command_i, now_ms_i, reason_code_i
// output    out        out_valid_o/out_stall_i verdict_o, request_count_o, reason_out_o,
//                                             waited_ms_o, startup_timed_out_o
// config    in         cfg_we_i               cfg_index_i, cfg_data_i
//
// Every command yields exactly one result transaction. It passes the input register,
// then the decision logic into the result register. Throughput is one transaction per
// cycle while the output is not stalled; the only loop is the gate state in shrc_core,
// which updates in the same cycle as its result is registered.
// Reset clears the gate state, both valid flags and loads the configuration
// registers with their default values (debounce 1000 ms, startup timeout 30000 ms).
// A stall on the output holds the result register; the input register still
// takes a new transaction while it is empty, and stalls only when both registers
// are full and the output is stalled.

module startup_hold_request_coalescer import shrc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         command_i,
  input  wire logic [TimeW-1:0]   now_ms_i,
  input  wire logic [ReasonW-1:0] reason_code_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              verdict_o,
  output logic [CountW-1:0]       request_count_o,
  output logic [ReasonW-1:0]      reason_out_o,
  output logic [TimeW-1:0]        waited_ms_o,
  output logic                    startup_timed_out_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  logic [CfgW-1:0] debounce_q;
  logic [CfgW-1:0] timeout_q;

  logic               in_valid_q;
  logic [1:0]         cmd_q;
  logic [TimeW-1:0]   now_q;
  logic [ReasonW-1:0] reason_q;

  logic    out_valid_q;
  result_t result_q;
  result_t result_d;

  logic advance;
  logic in_take;

  // Move the held command into the result register when that slot frees up.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Configuration registers; the user must make writes only while the gate is idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
      timeout_q  <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_DEBOUNCE) begin
        debounce_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_TIMEOUT) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  // Input register: hold the command until the decision stage takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q    <= command_i;
      now_q    <= now_ms_i;
      reason_q <= reason_code_i;
    end
  end

  shrc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .command_i     (cmd_q),
    .now_ms_i      (now_q),
    .reason_code_i (reason_q),
    .debounce_i    (debounce_q),
    .timeout_i     (timeout_q),
    .result_o      (result_d)
  );

  // Result register: drop the valid flag once the transaction is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign verdict_o           = result_q.verdict;
  assign request_count_o     = result_q.count;
  assign reason_out_o        = result_q.reason;
  assign waited_ms_o         = result_q.waited;
  assign startup_timed_out_o = result_q.timed_out;

  // The input side stalls only when both registers are full and the output is stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a full pipeline");

  a_debounced_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && verdict_o == VERDICT_DEBOUNCED) |->
      (request_count_o == '0 && waited_ms_o == '0 && !startup_timed_out_o))
    else $error("debounced result carries count, wait or timeout");

  a_queued_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && verdict_o == VERDICT_QUEUED) |->
      (request_count_o == 16'd1 && waited_ms_o == '0 && !startup_timed_out_o))
    else $error("first queued request must report count one and no wait");

  a_rebuild_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && verdict_o == VERDICT_REBUILD) |-> (request_count_o != '0))
    else $error("rebuild released with zero requests");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && verdict_o == VERDICT_IDLE) |->
      (request_count_o == '0 && reason_out_o == '0 && waited_ms_o == '0))
    else $error("idle result not all zero");

endmodule

`default_nettype wire
